### sv/selective_repeat_receiver_window_macros.svh
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SRRW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srrw assertion failed");

// next-cycle implication, disabled while reset is held
`define SRRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srrw assertion failed");

`endif

### sv/srrw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

  localparam int unsigned WINDOW = 8;

  localparam logic [1:0] OP_DATA     = 2'd0;
  localparam logic [1:0] OP_SETUP    = 2'd1;
  localparam logic [1:0] OP_TEARDOWN = 2'd2;

  localparam logic [1:0] CTL_DATA     = 2'd0;
  localparam logic [1:0] CTL_SETUP    = 2'd1;
  localparam logic [1:0] CTL_TEARDOWN = 2'd2;

  localparam logic RK_DELIVER = 1'b0;
  localparam logic RK_ACK     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_DELIV = 3'b100
  } state_t;

  typedef struct packed {
    logic wr_en;  // store a tag at offset wr_off from the ring base
    logic adv;    // slide the ring base by one slot
  } mem_ctl_t;

endpackage

`default_nettype wire

### sv/srrw_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module srrw_slot_mem #(
  parameter int unsigned WINDOW = srrw_pkg::WINDOW,
  localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire srrw_pkg::mem_ctl_t ctl,
  input  wire logic [PW-1:0]    wr_off,
  input  wire logic [31:0]      wr_data,
  output logic      [31:0]      rd_data
);

  localparam logic [PW:0] WIN_W = (PW + 1)'(WINDOW);

  logic [31:0]   slot_mem [WINDOW];
  logic [PW-1:0] base_r, base_nxt;
  logic [31:0]   rd_data_r;
  logic [PW:0]   wr_sum;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] base_inc;
  logic [PW-1:0] rd_addr;

  // ring addressing: logical slot i lives at (base + i) mod WINDOW
  always_comb begin
    wr_sum   = {1'b0, base_r} + {1'b0, wr_off};
    wr_addr  = (wr_sum >= WIN_W) ? PW'(wr_sum - WIN_W) : wr_sum[PW-1:0];
    base_inc = ({1'b0, base_r} == WIN_W - 1'b1) ? '0 : base_r + 1'b1;
    rd_addr  = ctl.adv ? base_inc : base_r;
    base_nxt = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

  // read the head slot every cycle, forward a same-cycle write
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (ctl.wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/selective_repeat_receiver_window.sv
// channel   ports                                         handshake
// input     in_opcode, in_seq_number, in_payload_tag      start && !busy
// result    out_result_kind, out_seq_number,              out_valid, one cycle
//           out_payload_tag, out_ack_control, out_last
//
// setup, teardown, old data and dropped words: busy while evaluated; no new word while busy.
// in-window data: busy while the word is stored and its run delivered, one payload per
// read of the one-read-per-cycle walk of the slot memory from the head.
// reset (rst_n low, synchronous) empties the window and sets the head to 0.
// results are registered; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

`include "selective_repeat_receiver_window_macros.svh"

module selective_repeat_receiver_window #(
  parameter int unsigned WINDOW = srrw_pkg::WINDOW,
  localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_seq_number,
  input  wire logic [31:0] in_payload_tag,
  output logic             out_valid,
  output logic             out_result_kind,
  output logic [31:0]      out_seq_number,
  output logic [31:0]      out_payload_tag,
  output logic [1:0]       out_ack_control,
  output logic             out_last
);

  srrw_pkg::state_t state_r, state_nxt;
  logic [31:0]       head_r, head_nxt;
  logic [WINDOW-1:0] marks_r, marks_nxt;
  logic [1:0]        op_r;
  logic [31:0]       seq_r;
  logic [31:0]       tag_r;

  logic        ov_r, ov_nxt;
  logic        okind_r, okind_nxt;
  logic [31:0] oseq_r, oseq_nxt;
  logic [31:0] otag_r, otag_nxt;
  logic [1:0]  octl_r, octl_nxt;
  logic        olast_r, olast_nxt;

  srrw_pkg::mem_ctl_t mem_ctl;
  logic [31:0]        rd_data;
  logic               below;
  logic [31:0]        off;
  logic               in_win;
  logic [PW-1:0]      off_idx;
  logic [WINDOW-1:0]  off_bit;
  logic               accept;

  assign accept  = start && (state_r == srrw_pkg::ST_IDLE);
  assign busy    = (state_r != srrw_pkg::ST_IDLE);

  assign below   = seq_r < head_r;
  assign off     = seq_r - head_r;
  assign in_win  = !below && (off < 32'(WINDOW));
  assign off_idx = off[PW-1:0];
  assign off_bit = WINDOW'(1) << off_idx;

  srrw_slot_mem #(.WINDOW(WINDOW)) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_off  (off_idx),
    .wr_data (tag_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    marks_nxt     = marks_r;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.adv   = 1'b0;
    ov_nxt        = 1'b0;
    okind_nxt     = srrw_pkg::RK_ACK;
    oseq_nxt      = seq_r;
    otag_nxt      = '0;
    octl_nxt      = srrw_pkg::CTL_DATA;
    olast_nxt     = 1'b1;
    case (state_r)
      srrw_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = srrw_pkg::ST_EVAL;
        end
      end
      srrw_pkg::ST_EVAL: begin
        state_nxt = srrw_pkg::ST_IDLE;
        case (op_r)
          srrw_pkg::OP_SETUP: begin
            marks_nxt = '0;
            head_nxt  = seq_r + 32'd1;
            ov_nxt    = 1'b1;
            octl_nxt  = srrw_pkg::CTL_SETUP;
          end
          srrw_pkg::OP_TEARDOWN: begin
            ov_nxt   = 1'b1;
            octl_nxt = srrw_pkg::CTL_TEARDOWN;
          end
          srrw_pkg::OP_DATA: begin
            if (below) begin
              ov_nxt = 1'b1;
            end else if (in_win) begin
              // first copy of a slot wins
              mem_ctl.wr_en = ((marks_r & off_bit) == '0);
              marks_nxt     = marks_r | off_bit;
              state_nxt     = srrw_pkg::ST_DELIV;
            end
          end
          default: begin
          end
        endcase
      end
      srrw_pkg::ST_DELIV: begin
        if (marks_r[0]) begin
          ov_nxt      = 1'b1;
          okind_nxt   = srrw_pkg::RK_DELIVER;
          oseq_nxt    = head_r;
          otag_nxt    = rd_data;
          olast_nxt   = 1'b0;
          head_nxt    = head_r + 32'd1;
          marks_nxt   = marks_r >> 1;
          mem_ctl.adv = 1'b1;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = srrw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srrw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srrw_pkg::ST_IDLE;
      head_r  <= '0;
      marks_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      marks_r <= marks_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      seq_r <= in_seq_number;
      tag_r <= in_payload_tag;
    end
    okind_r <= okind_nxt;
    oseq_r  <= oseq_nxt;
    otag_r  <= otag_nxt;
    octl_r  <= octl_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_result_kind = okind_r;
  assign out_seq_number  = oseq_r;
  assign out_payload_tag = otag_r;
  assign out_ack_control = octl_r;
  assign out_last        = olast_r;

  `SRRW_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `SRRW_ASSERT_NOW(a_last_idle, clk, rst_n, out_valid && out_last, !busy)
  `SRRW_ASSERT_NOW(a_deliver_not_last, clk, rst_n,
    out_valid && (out_result_kind == srrw_pkg::RK_DELIVER), !out_last)
  `SRRW_ASSERT_NOW(a_idle_head_empty, clk, rst_n,
    state_r == srrw_pkg::ST_IDLE, !marks_r[0])

endmodule

`default_nettype wire
